// ===== rtl/cpu_6502_bus_cycle_core_defines.svh =====
// assertion macros used by the core's top-level rtl file
`ifndef CPU_6502_BUS_CYCLE_CORE_DEFINES_SVH
`define CPU_6502_BUS_CYCLE_CORE_DEFINES_SVH

// clocked assertion, off during reset
`define C6BC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define C6BC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/c6bc_pkg.sv =====
// types, constants and decode helpers for the 6502 bus cycle core
`default_nettype none
package c6bc_pkg;

  localparam logic [7:0]  FLAGS_RESET = 8'h04;
  localparam logic [7:0]  PUSH_BITS   = 8'h30;
  localparam logic [7:0]  PULL_MASK   = 8'hCF;
  localparam logic [7:0]  STACK_PAGE  = 8'h01;
  localparam logic [15:0] VECTOR_LOW  = 16'hFFFE;
  localparam logic [15:0] VECTOR_HIGH = 16'hFFFF;
  localparam logic [7:0]  STACK_RESET = 8'd253;

  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

  // opcodes with special handling
  localparam logic [7:0] OP_BRK = 8'h00;
  localparam logic [7:0] OP_PHP = 8'h08;
  localparam logic [7:0] OP_JSR = 8'h20;
  localparam logic [7:0] OP_PLP = 8'h28;
  localparam logic [7:0] OP_RTI = 8'h40;
  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_RTS = 8'h60;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_STA_IMM = 8'h89;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_TXS = 8'h9A;
  localparam logic [7:0] OP_TSX = 8'hBA;
  localparam logic [7:0] OP_ASL = 8'h0A;
  localparam logic [7:0] OP_ROL = 8'h2A;
  localparam logic [7:0] OP_LSR = 8'h4A;
  localparam logic [7:0] OP_ROR = 8'h6A;
  localparam logic [7:0] OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TYA = 8'h98;
  localparam logic [7:0] OP_TAX = 8'hAA;
  localparam logic [7:0] OP_TAY = 8'hA8;
  localparam logic [7:0] OP_DEX = 8'hCA;
  localparam logic [7:0] OP_INX = 8'hE8;
  localparam logic [7:0] OP_DEY = 8'h88;
  localparam logic [7:0] OP_INY = 8'hC8;
  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_SEC = 8'h38;
  localparam logic [7:0] OP_CLI = 8'h58;
  localparam logic [7:0] OP_SEI = 8'h78;
  localparam logic [7:0] OP_CLV = 8'hB8;
  localparam logic [7:0] OP_CLD = 8'hD8;
  localparam logic [7:0] OP_SED = 8'hF8;

  typedef enum logic [4:0] {
    MD_ILL, MD_IMP, MD_IMM, MD_ZP, MD_ZPX, MD_ZPY, MD_ABS, MD_ABX, MD_ABY,
    MD_INX, MD_INY, MD_REL, MD_JMP, MD_JMPI, MD_JSR, MD_RTS, MD_RTI, MD_BRK,
    MD_PUSH, MD_PULL
  } mode_t;

  typedef enum logic [1:0] {KIND_READ, KIND_WRITE, KIND_RMW} kind_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  p;
    logic [7:0]  sp;
    logic [15:0] pc;
    logic [7:0]  ir;
    logic [2:0]  step;
    logic [15:0] ea;
    logic [7:0]  op;
  } state_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        fetch;
  } bus_t;

  function automatic mode_t decode(input logic [7:0] opc);
    logic [2:0] aaa;
    logic [2:0] bbb;
    logic [1:0] cc;
    mode_t md;
    aaa = opc[7:5];
    bbb = opc[4:2];
    cc  = opc[1:0];
    md  = MD_ILL;
    case (cc)
      2'd1: begin
        case (bbb)
          3'd0: md = MD_INX;
          3'd1: md = MD_ZP;
          3'd2: md = (opc == OP_STA_IMM) ? MD_ILL : MD_IMM;
          3'd3: md = MD_ABS;
          3'd4: md = MD_INY;
          3'd5: md = MD_ZPX;
          3'd6: md = MD_ABY;
          default: md = MD_ABX;
        endcase
      end
      2'd2: begin
        case (bbb)
          3'd0: md = (opc == OP_LDX_IMM) ? MD_IMM : MD_ILL;
          3'd1: md = MD_ZP;
          3'd2: md = MD_IMP;
          3'd3: md = MD_ABS;
          3'd5: md = (aaa == 3'd4 || aaa == 3'd5) ? MD_ZPY : MD_ZPX;
          3'd6: md = (opc == OP_TXS || opc == OP_TSX) ? MD_IMP : MD_ILL;
          3'd7: md = (aaa == 3'd5) ? MD_ABY : (aaa == 3'd4) ? MD_ILL : MD_ABX;
          default: md = MD_ILL;
        endcase
      end
      2'd0: begin
        case (bbb)
          3'd0: begin
            if (opc == OP_BRK) md = MD_BRK;
            else if (opc == OP_JSR) md = MD_JSR;
            else if (opc == OP_RTI) md = MD_RTI;
            else if (opc == OP_RTS) md = MD_RTS;
            else md = (aaa >= 3'd5) ? MD_IMM : MD_ILL;
          end
          3'd1: md = (aaa == 3'd1 || aaa >= 3'd4) ? MD_ZP : MD_ILL;
          3'd2: begin
            if (opc == OP_PHP || opc == OP_PHA) md = MD_PUSH;
            else if (opc == OP_PLP || opc == OP_PLA) md = MD_PULL;
            else md = MD_IMP;
          end
          3'd3: begin
            if (aaa == 3'd2) md = MD_JMP;
            else if (aaa == 3'd3) md = MD_JMPI;
            else md = (aaa == 3'd0) ? MD_ILL : MD_ABS;
          end
          3'd4: md = MD_REL;
          3'd5: md = (aaa == 3'd4 || aaa == 3'd5) ? MD_ZPX : MD_ILL;
          3'd6: md = MD_IMP;
          default: md = (aaa == 3'd5) ? MD_ABX : MD_ILL;
        endcase
      end
      default: md = MD_ILL;
    endcase
    return md;
  endfunction

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] r);
    logic [7:0] q;
    q = p;
    q[FL_Z] = (r == 8'h00);
    q[FL_N] = r[7];
    return q;
  endfunction

  function automatic logic [7:0] do_compare(input logic [7:0] p, input logic [7:0] r,
                                            input logic [7:0] v);
    logic [7:0] q;
    q = set_nz(p, r - v);
    q[FL_C] = (r >= v);
    return q;
  endfunction

  // returns {carry, result}
  function automatic logic [8:0] do_shift(input logic [2:0] aaa, input logic [7:0] v,
                                          input logic cin);
    logic [8:0] o;
    case (aaa)
      3'd0: o = {v[7], v[6:0], 1'b0};
      3'd1: o = {v[7], v[6:0], cin};
      3'd2: o = {v[0], 1'b0, v[7:1]};
      3'd3: o = {v[0], cin, v[7:1]};
      3'd6: o = {cin, v - 8'd1};
      default: o = {cin, v + 8'd1};
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/c6bc_step.sv =====
// next-state and bus access logic for one bus cycle
`default_nettype none
module c6bc_step (
  input  wire c6bc_pkg::state_t st,
  input  wire logic [7:0]       din,
  input  wire logic [15:0]      start_address,
  input  wire logic [7:0]       start_stack,
  output c6bc_pkg::state_t      st_next,
  output c6bc_pkg::bus_t        res
);

  c6bc_pkg::state_t  n;
  c6bc_pkg::bus_t    b;
  c6bc_pkg::mode_t   mode;
  c6bc_pkg::kind_t   kind;
  logic [2:0]  s;
  logic [2:0]  m;
  logic [2:0]  aaa;
  logic [1:0]  cc;
  logic [15:0] word;
  logic [8:0]  sum;
  logic [8:0]  sh;
  logic [7:0]  opnd;
  logic        do_fetch;

  always_comb begin
    n        = st;
    b        = '0;
    s        = st.step;
    do_fetch = 1'b0;
    n.ir     = (s == 3'd1) ? din : st.ir;
    mode     = c6bc_pkg::decode(n.ir);
    aaa      = n.ir[7:5];
    cc       = n.ir[1:0];
    word     = {din, st.op};
    sum      = '0;
    sh       = '0;
    opnd     = din;
    if (aaa == 3'd4) kind = c6bc_pkg::KIND_WRITE;
    else if (cc == 2'd2 && aaa != 3'd5) kind = c6bc_pkg::KIND_RMW;
    else kind = c6bc_pkg::KIND_READ;
    if (mode == c6bc_pkg::MD_IMM) m = 3'd1;
    else if (mode <= c6bc_pkg::MD_ZPY) m = 3'd2;
    else if (mode <= c6bc_pkg::MD_ABY) m = 3'd3;
    else m = 3'd4;

    if (s == 3'd0) begin
      n.pc     = start_address;
      n.sp     = start_stack;
      do_fetch = 1'b1;
    end else begin
      n.step = s + 3'd1;
      if (mode >= c6bc_pkg::MD_IMM && mode <= c6bc_pkg::MD_INY) begin
        if (s < m) begin
          if (s == 3'd1) begin
            b.addr = n.pc;
            n.pc   = n.pc + 16'd1;
          end else if (s == 3'd2 && mode <= c6bc_pkg::MD_ABY) begin
            n.op   = din;
            b.addr = n.pc;
            n.pc   = n.pc + 16'd1;
          end else if (s == 3'd2) begin
            n.ea   = {8'h00, (mode == c6bc_pkg::MD_INX) ? din + st.x : din};
            b.addr = n.ea;
          end else begin
            n.op   = din;
            b.addr = {8'h00, st.ea[7:0] + 8'd1};
          end
        end else if (s == m) begin
          case (mode)
            c6bc_pkg::MD_IMM: begin
              n.ea = n.pc;
              n.pc = n.pc + 16'd1;
            end
            c6bc_pkg::MD_ZP:  n.ea = {8'h00, din};
            c6bc_pkg::MD_ZPX: n.ea = {8'h00, din + st.x};
            c6bc_pkg::MD_ZPY: n.ea = {8'h00, din + st.y};
            c6bc_pkg::MD_ABX: n.ea = word + {8'h00, st.x};
            c6bc_pkg::MD_ABY, c6bc_pkg::MD_INY: n.ea = word + {8'h00, st.y};
            default: n.ea = word;
          endcase
          b.addr = n.ea;
          if (kind == c6bc_pkg::KIND_WRITE) begin
            b.wr    = 1'b1;
            b.wdata = (cc == 2'd1) ? st.a : (cc == 2'd2) ? st.x : st.y;
          end
        end else if (s == m + 3'd1 && kind == c6bc_pkg::KIND_RMW) begin
          sh            = c6bc_pkg::do_shift(aaa, din, st.p[c6bc_pkg::FL_C]);
          n.p           = c6bc_pkg::set_nz(st.p, sh[7:0]);
          n.p[c6bc_pkg::FL_C] = sh[8];
          n.op          = sh[7:0];
          b.addr        = st.ea;
          b.wr          = 1'b1;
          b.wdata       = sh[7:0];
        end else begin
          if (s == m + 3'd1 && kind == c6bc_pkg::KIND_READ) begin
            if (cc == 2'd1) begin
              case (aaa)
                3'd0: begin n.a = st.a | din; n.p = c6bc_pkg::set_nz(st.p, n.a); end
                3'd1: begin n.a = st.a & din; n.p = c6bc_pkg::set_nz(st.p, n.a); end
                3'd2: begin n.a = st.a ^ din; n.p = c6bc_pkg::set_nz(st.p, n.a); end
                3'd3, 3'd7: begin
                  opnd = (aaa == 3'd7) ? ~din : din;
                  sum  = {1'b0, st.a} + {1'b0, opnd} + {8'h00, st.p[c6bc_pkg::FL_C]};
                  n.a  = sum[7:0];
                  n.p  = c6bc_pkg::set_nz(st.p, sum[7:0]);
                  n.p[c6bc_pkg::FL_C] = sum[8];
                  n.p[c6bc_pkg::FL_V] = ~(st.a[7] ^ opnd[7]) & (st.a[7] ^ sum[7]);
                end
                3'd5: begin n.a = din; n.p = c6bc_pkg::set_nz(st.p, din); end
                3'd6: n.p = c6bc_pkg::do_compare(st.p, st.a, din);
                default: ;
              endcase
            end else if (cc == 2'd2) begin
              n.x = din;
              n.p = c6bc_pkg::set_nz(st.p, din);
            end else begin
              case (aaa)
                3'd1: begin
                  n.p[c6bc_pkg::FL_Z] = ((st.a & din) == 8'h00);
                  n.p[c6bc_pkg::FL_N] = din[7];
                  n.p[c6bc_pkg::FL_V] = din[6];
                end
                3'd5: begin n.y = din; n.p = c6bc_pkg::set_nz(st.p, din); end
                3'd6: n.p = c6bc_pkg::do_compare(st.p, st.y, din);
                3'd7: n.p = c6bc_pkg::do_compare(st.p, st.x, din);
                default: ;
              endcase
            end
          end
          do_fetch = 1'b1;
        end
      end else begin
        case (mode)
          c6bc_pkg::MD_IMP: begin
            case (n.ir)
              c6bc_pkg::OP_ASL, c6bc_pkg::OP_ROL, c6bc_pkg::OP_LSR, c6bc_pkg::OP_ROR: begin
                sh  = c6bc_pkg::do_shift(aaa, st.a, st.p[c6bc_pkg::FL_C]);
                n.a = sh[7:0];
                n.p = c6bc_pkg::set_nz(st.p, sh[7:0]);
                n.p[c6bc_pkg::FL_C] = sh[8];
              end
              c6bc_pkg::OP_TXA: begin n.a = st.x; n.p = c6bc_pkg::set_nz(st.p, st.x); end
              c6bc_pkg::OP_TYA: begin n.a = st.y; n.p = c6bc_pkg::set_nz(st.p, st.y); end
              c6bc_pkg::OP_TAX: begin n.x = st.a; n.p = c6bc_pkg::set_nz(st.p, st.a); end
              c6bc_pkg::OP_TAY: begin n.y = st.a; n.p = c6bc_pkg::set_nz(st.p, st.a); end
              c6bc_pkg::OP_TSX: begin n.x = st.sp; n.p = c6bc_pkg::set_nz(st.p, st.sp); end
              c6bc_pkg::OP_TXS: n.sp = st.x;
              c6bc_pkg::OP_DEX: begin n.x = st.x - 8'd1; n.p = c6bc_pkg::set_nz(st.p, n.x); end
              c6bc_pkg::OP_INX: begin n.x = st.x + 8'd1; n.p = c6bc_pkg::set_nz(st.p, n.x); end
              c6bc_pkg::OP_DEY: begin n.y = st.y - 8'd1; n.p = c6bc_pkg::set_nz(st.p, n.y); end
              c6bc_pkg::OP_INY: begin n.y = st.y + 8'd1; n.p = c6bc_pkg::set_nz(st.p, n.y); end
              c6bc_pkg::OP_CLC: n.p[c6bc_pkg::FL_C] = 1'b0;
              c6bc_pkg::OP_SEC: n.p[c6bc_pkg::FL_C] = 1'b1;
              c6bc_pkg::OP_CLI: n.p[c6bc_pkg::FL_I] = 1'b0;
              c6bc_pkg::OP_SEI: n.p[c6bc_pkg::FL_I] = 1'b1;
              c6bc_pkg::OP_CLV: n.p[c6bc_pkg::FL_V] = 1'b0;
              c6bc_pkg::OP_CLD: n.p[c6bc_pkg::FL_D] = 1'b0;
              c6bc_pkg::OP_SED: n.p[c6bc_pkg::FL_D] = 1'b1;
              default: ;
            endcase
            do_fetch = 1'b1;
          end
          c6bc_pkg::MD_REL: begin
            if (s == 3'd1) begin
              b.addr = n.pc;
              n.pc   = n.pc + 16'd1;
            end else begin
              case (n.ir[7:6])
                2'd0: opnd[0] = st.p[c6bc_pkg::FL_N];
                2'd1: opnd[0] = st.p[c6bc_pkg::FL_V];
                2'd2: opnd[0] = st.p[c6bc_pkg::FL_C];
                default: opnd[0] = st.p[c6bc_pkg::FL_Z];
              endcase
              if (opnd[0] == n.ir[5]) n.pc = n.pc + {{8{din[7]}}, din};
              do_fetch = 1'b1;
            end
          end
          c6bc_pkg::MD_JMP, c6bc_pkg::MD_JMPI: begin
            if (s == 3'd1) begin
              b.addr = n.pc;
              n.pc   = n.pc + 16'd1;
            end else if (s == 3'd2) begin
              n.op   = din;
              b.addr = n.pc;
              n.pc   = n.pc + 16'd1;
            end else if (s == 3'd3 && mode == c6bc_pkg::MD_JMPI) begin
              n.ea   = word;
              b.addr = word;
            end else if (s == 3'd4 && mode == c6bc_pkg::MD_JMPI) begin
              n.op   = din;
              b.addr = st.ea + 16'd1;
            end else begin
              n.pc     = word;
              do_fetch = 1'b1;
            end
          end
          c6bc_pkg::MD_JSR: begin
            if (s == 3'd1) begin
              b.addr = n.pc;
              n.pc   = n.pc + 16'd1;
            end else if (s == 3'd2 || s == 3'd3) begin
              if (s == 3'd2) n.op = din;
              b.addr  = {c6bc_pkg::STACK_PAGE, st.sp};
              b.wr    = 1'b1;
              b.wdata = (s == 3'd2) ? st.pc[15:8] : st.pc[7:0];
              n.sp    = st.sp - 8'd1;
            end else if (s == 3'd4) begin
              b.addr = st.pc;
            end else begin
              n.pc     = word;
              do_fetch = 1'b1;
            end
          end
          c6bc_pkg::MD_RTS, c6bc_pkg::MD_RTI: begin
            if (s == 3'd1 || s == 3'd2 || (s == 3'd3 && mode == c6bc_pkg::MD_RTI)) begin
              if (mode == c6bc_pkg::MD_RTI && s == 3'd2) n.p = din & c6bc_pkg::PULL_MASK;
              else if (s != 3'd1) n.op = din;
              n.sp   = st.sp + 8'd1;
              b.addr = {c6bc_pkg::STACK_PAGE, n.sp};
            end else begin
              n.pc     = (mode == c6bc_pkg::MD_RTS) ? word + 16'd1 : word;
              do_fetch = 1'b1;
            end
          end
          c6bc_pkg::MD_BRK: begin
            if (s == 3'd1 || s == 3'd2 || s == 3'd3) begin
              if (s == 3'd1) n.pc = st.pc + 16'd1;
              b.addr = {c6bc_pkg::STACK_PAGE, st.sp};
              b.wr   = 1'b1;
              n.sp   = st.sp - 8'd1;
              case (s)
                3'd1: b.wdata = n.pc[15:8];
                3'd2: b.wdata = st.pc[7:0];
                default: begin
                  b.wdata = st.p | c6bc_pkg::PUSH_BITS;
                  n.p[c6bc_pkg::FL_I] = 1'b1;
                end
              endcase
            end else if (s == 3'd4) begin
              b.addr = c6bc_pkg::VECTOR_LOW;
            end else if (s == 3'd5) begin
              n.op   = din;
              b.addr = c6bc_pkg::VECTOR_HIGH;
            end else begin
              n.pc     = word;
              do_fetch = 1'b1;
            end
          end
          c6bc_pkg::MD_PUSH: begin
            if (s == 3'd1) begin
              b.addr  = {c6bc_pkg::STACK_PAGE, st.sp};
              b.wr    = 1'b1;
              b.wdata = (n.ir == c6bc_pkg::OP_PHA) ? st.a : (st.p | c6bc_pkg::PUSH_BITS);
              n.sp    = st.sp - 8'd1;
            end else begin
              do_fetch = 1'b1;
            end
          end
          c6bc_pkg::MD_PULL: begin
            if (s == 3'd1) begin
              n.sp   = st.sp + 8'd1;
              b.addr = {c6bc_pkg::STACK_PAGE, n.sp};
            end else begin
              if (n.ir == c6bc_pkg::OP_PLA) begin
                n.a = din;
                n.p = c6bc_pkg::set_nz(st.p, din);
              end else begin
                n.p = din & c6bc_pkg::PULL_MASK;
              end
              do_fetch = 1'b1;
            end
          end
          default: do_fetch = 1'b1;
        endcase
      end
    end

    if (do_fetch) begin
      b       = '0;
      b.addr  = n.pc;
      b.fetch = 1'b1;
      n.pc    = n.pc + 16'd1;
      n.step  = 3'd1;
    end
    st_next = n;
    res     = b;
  end

endmodule
`default_nettype wire

// ===== rtl/cpu_6502_bus_cycle_core.sv =====
// top level of the 6502 bus cycle core: handshake, config port and state registers
// Each input item carries the byte read on the previous bus cycle and yields
// exactly one result item describing the next bus access (address, read or
// write, write data, opcode fetch mark). An item passes an input register,
// one level of decode and execute logic, and a result register, so the core
// takes one item every clock as long as results are drained. The first item
// after reset is ignored and starts the opcode fetch at start_address with the
// stack offset taken from start_stack. Configuration is written through the
// apb-style port at byte addresses 0 (start_address) and 4 (start_stack); the
// user writes it only while the core is idle, which the core does not enforce.
`default_nettype none
`include "cpu_6502_bus_cycle_core_defines.svh"
module cpu_6502_bus_cycle_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb-style configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  bus_read_data,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      bus_address,
  output logic             bus_write,
  output logic [7:0]       bus_write_data,
  output logic             opcode_fetch
);

  logic [15:0]       start_address;
  logic [7:0]        start_stack;
  logic              in_full;
  logic [7:0]        in_data;
  logic              advance;
  c6bc_pkg::state_t  st;
  c6bc_pkg::state_t  st_next;
  c6bc_pkg::bus_t    res;

  // config registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
      start_stack   <= c6bc_pkg::STACK_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) start_stack <= pwdata[7:0];
      else start_address <= pwdata[15:0];
    end
  end
  assign prdata = paddr[2] ? {24'h0, start_stack} : {16'h0, start_address};

  // input register moves into the result register when that one is free
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data <= bus_read_data;
  end

  // one bus cycle of the processor
  c6bc_step u_step (
    .st            (st),
    .din           (in_data),
    .start_address (start_address),
    .start_stack   (start_stack),
    .st_next       (st_next),
    .res           (res)
  );

  // architectural state, updated as an item is executed
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{p: c6bc_pkg::FLAGS_RESET, sp: c6bc_pkg::STACK_RESET, default: '0};
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bus_address    <= res.addr;
      bus_write      <= res.wr;
      bus_write_data <= res.wdata;
      opcode_fetch   <= res.fetch;
    end
  end

  // a fetch is never a write
  `C6BC_ASSERT(a_fetch_read, out_valid |-> !(bus_write && opcode_fetch), "fetch marked as write")
  // read accesses carry zero data
  `C6BC_ASSERT(a_read_zero, (out_valid && !bus_write) |-> (bus_write_data == 8'h00), "data on read")
  // after an opcode fetch the sequencer waits for the opcode byte
  `C6BC_ASSERT(a_fetch_step, (advance && res.fetch) |=> (st.step == 3'd1), "bad step after fetch")
  // the start step is left after the first executed item
  `C6BC_ASSERT(a_step_run, advance |=> (st.step != 3'd0), "sequencer back at start")

endmodule
`default_nettype wire
